// File: hdl/tvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvt_pkg: shared types and constants of the vertex transform
// Holds payload structs, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package tvt_pkg;

  localparam int CW = 32;
  localparam int FRAC = 16;
  localparam int NUM_REGS = 8;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_TX = 3'd0;
  localparam logic [IDX_W-1:0] REG_TY = 3'd1;
  localparam logic [IDX_W-1:0] REG_TZ = 3'd2;
  localparam logic [IDX_W-1:0] REG_QXY = 3'd3;
  localparam logic [IDX_W-1:0] REG_QZW = 3'd4;
  localparam logic [IDX_W-1:0] REG_SX = 3'd5;
  localparam logic [IDX_W-1:0] REG_SY = 3'd6;
  localparam logic [IDX_W-1:0] REG_SZ = 3'd7;

  localparam logic [31:0] QZW_RESET = 32'h4000_0000;
  localparam logic signed [CW-1:0] ONE_Q16 = CW'(65536);

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] result_x;
    logic signed [CW-1:0] result_y;
    logic signed [CW-1:0] result_z;
    logic saturated;
    logic degenerate_rotation;
  } out_item_t;

  // One matrix row: three coefficients and translation
  typedef struct packed {
    logic signed [CW-1:0] m0;
    logic signed [CW-1:0] m1;
    logic signed [CW-1:0] m2;
    logic signed [CW-1:0] t;
  } row_t;

  // Status between the matrix builder and the top level
  typedef struct packed {
    logic busy;
    logic degenerate;
  } build_stat_t;

endpackage

// File: hdl/tvt_matrix_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvt_matrix_build: rebuild the 3x4 matrix after a register write
// Sequences nine numerators through one restoring divider, then scales; a zero quaternion skips the divider.
// ----------------------------------------------------------------------------
module tvt_matrix_build (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          kick,
  input  logic [31:0]                   qxy,
  input  logic [31:0]                   qzw,
  input  logic signed [tvt_pkg::CW-1:0] sx,
  input  logic signed [tvt_pkg::CW-1:0] sy,
  input  logic signed [tvt_pkg::CW-1:0] sz,
  output logic signed [tvt_pkg::CW-1:0] coef_o [9],
  output tvt_pkg::build_stat_t          stat
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQ   = 5'b00010,
    ST_NUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_SCL  = 5'b10000
  } st_t;

  localparam int SW = 33;   // sum of four squares of 16-bit values
  localparam int DW = SW + tvt_pkg::FRAC + 1;
  localparam int RW = 18;   // |ratio| <= 65536

  st_t st_r, st_nxt;
  logic signed [15:0] x_r, y_r, z_r, w_r;
  logic signed [SW:0] xx_r, yy_r, zz_r, ww_r, xy_r, zw_r, xz_r, yw_r, yz_r, xw_r;
  logic [SW-1:0] s_r;
  logic [SW-1:0] s_sum;
  logic signed [SW+2:0] num_r [9];
  logic [3:0] ci_r;
  logic [5:0] bit_r;
  logic [DW-1:0] rem_r, quo_r;
  logic signed [RW-1:0] rot_r [9];
  logic degen_r;
  logic signed [tvt_pkg::CW-1:0] coef_r [9];
  logic [DW:0] trial;
  logic [DW-1:0] dividend;
  logic [SW+2:0] mag;
  logic signed [tvt_pkg::CW-1:0] scl_sel;
  logic signed [RW+tvt_pkg::CW:0] prod;
  logic signed [RW+tvt_pkg::CW-tvt_pkg::FRAC:0] shf;

  // Sum of squares from the registered products
  assign s_sum = SW'(xx_r + yy_r + zz_r + ww_r);

  // Sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (kick) st_nxt = ST_SQ;
      ST_SQ:   st_nxt = ST_NUM;
      ST_NUM:  st_nxt = (s_sum == '0) ? ST_SCL : ST_DIV;
      ST_DIV:  if (bit_r == '0 && ci_r == 4'd8) st_nxt = ST_SCL;
      ST_SCL:  if (ci_r == 4'd8) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Divider and scaling datapath: one quotient bit per cycle
  always_comb begin
    mag = num_r[ci_r][SW+2] ? (SW+3)'(0) - $unsigned(num_r[ci_r])
                            : $unsigned(num_r[ci_r]);
    dividend = (DW'(mag) << tvt_pkg::FRAC) + DW'(s_r >> 1);
    trial = {rem_r, dividend[bit_r]} - {{(DW-SW+1){1'b0}}, s_r};
    if (ci_r == 4'd0 || ci_r == 4'd3 || ci_r == 4'd6) scl_sel = sx;
    else if (ci_r == 4'd1 || ci_r == 4'd4 || ci_r == 4'd7) scl_sel = sy;
    else scl_sel = sz;
    prod = rot_r[ci_r] * scl_sel + (RW+tvt_pkg::CW+1)'(32768);
    shf = (RW+tvt_pkg::CW-tvt_pkg::FRAC+1)'(prod >>> tvt_pkg::FRAC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      degen_r <= 1'b0;
      ci_r <= '0;
      for (int i = 0; i < 9; i++)
        coef_r[i] <= (i == 0 || i == 4 || i == 8) ? tvt_pkg::ONE_Q16 : '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          x_r <= qxy[15:0];  y_r <= qxy[31:16];
          z_r <= qzw[15:0];  w_r <= qzw[31:16];
          ci_r <= '0;
        end
        ST_SQ: begin
          xx_r <= x_r*x_r; yy_r <= y_r*y_r; zz_r <= z_r*z_r; ww_r <= w_r*w_r;
          xy_r <= x_r*y_r; zw_r <= z_r*w_r; xz_r <= x_r*z_r; yw_r <= y_r*w_r;
          yz_r <= y_r*z_r; xw_r <= x_r*w_r;
        end
        ST_NUM: begin
          s_r <= s_sum;
          num_r[0] <= (SW+3)'(xx_r + ww_r - yy_r - zz_r);
          num_r[3] <= (SW+3)'(2*(xy_r + zw_r));
          num_r[6] <= (SW+3)'(2*(xz_r - yw_r));
          num_r[1] <= (SW+3)'(2*(xy_r - zw_r));
          num_r[4] <= (SW+3)'(yy_r + ww_r - xx_r - zz_r);
          num_r[7] <= (SW+3)'(2*(yz_r + xw_r));
          num_r[2] <= (SW+3)'(2*(xz_r + yw_r));
          num_r[5] <= (SW+3)'(2*(yz_r - xw_r));
          num_r[8] <= (SW+3)'(zz_r + ww_r - xx_r - yy_r);
          degen_r <= (s_sum == '0);
          if (s_sum == '0)
            for (int i = 0; i < 9; i++)
              rot_r[i] <= (i == 0 || i == 4 || i == 8) ? RW'(65536) : '0;
          ci_r <= '0;
          bit_r <= 6'(DW-1);
          rem_r <= '0;
          quo_r <= '0;
        end
        ST_DIV: begin
          if (bit_r == '0) begin
            rot_r[ci_r] <= num_r[ci_r][SW+2]
                ? RW'(0) - RW'({quo_r[DW-2:0], ~trial[DW]})
                : RW'({quo_r[DW-2:0], ~trial[DW]});
            bit_r <= 6'(DW-1);
            rem_r <= '0;
            quo_r <= '0;
            ci_r <= (ci_r == 4'd8) ? 4'd0 : ci_r + 4'd1;
          end else begin
            if (!trial[DW]) begin
              rem_r <= trial[DW-1:0];
              quo_r <= {quo_r[DW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DW-2:0], dividend[bit_r]};
              quo_r <= {quo_r[DW-2:0], 1'b0};
            end
            bit_r <= bit_r - 6'd1;
          end
        end
        ST_SCL: begin
          if (shf > $signed((RW+tvt_pkg::CW-tvt_pkg::FRAC+1)'(32'sh7FFF_FFFF)))
            coef_r[ci_r] <= 32'sh7FFF_FFFF;
          else if (shf < -$signed((RW+tvt_pkg::CW-tvt_pkg::FRAC+1)'(33'sh0_8000_0000)))
            coef_r[ci_r] <= 32'sh8000_0000;
          else
            coef_r[ci_r] <= tvt_pkg::CW'(shf);
          ci_r <= ci_r + 4'd1;
        end
        default: ;
      endcase
    end
  end

  assign coef_o = coef_r;
  assign stat.busy = (st_r != ST_IDLE) || kick;
  assign stat.degenerate = degen_r;

endmodule

// File: hdl/tvt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvt_datapath: three-stage point transform pipeline
// Multiply, sum, round and saturate, one point per cycle.
// ----------------------------------------------------------------------------
module tvt_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  tvt_pkg::in_item_t     in_item,
  input  tvt_pkg::row_t         rows [3],
  input  logic                  degen,
  output logic                  out_vld,
  output tvt_pkg::out_item_t    out_item
);

  localparam int PW = 2*tvt_pkg::CW;
  localparam int AW = PW + 3;

  logic [2:0] v_r;
  logic [1:0] dg_r;
  logic signed [PW-1:0] p_r [3][3];
  logic signed [PW-1:0] t_r [3];
  logic signed [AW-1:0] acc_r [3];
  tvt_pkg::out_item_t o_r;
  logic signed [AW-tvt_pkg::FRAC-1:0] sh [3];
  logic signed [tvt_pkg::CW-1:0] res [3];
  logic ov [3];

  // Round and saturate each row
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sh[r] = (AW-tvt_pkg::FRAC)'(acc_r[r] >>> tvt_pkg::FRAC);
      ov[r] = (sh[r] > (AW-tvt_pkg::FRAC)'(signed'(32'sh7FFF_FFFF))) ||
              (sh[r] < (AW-tvt_pkg::FRAC)'(signed'(32'sh8000_0000)));
      res[r] = !ov[r] ? tvt_pkg::CW'(sh[r]) :
               (sh[r][AW-tvt_pkg::FRAC-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    // Stage 1: nine products and the translation terms
    for (int r = 0; r < 3; r++) begin
      p_r[r][0] <= rows[r].m0 * in_item.point_x;
      p_r[r][1] <= rows[r].m1 * in_item.point_y;
      p_r[r][2] <= rows[r].m2 * in_item.point_z;
      t_r[r] <= (PW'(rows[r].t) <<< tvt_pkg::FRAC) + PW'(32768);
    end
    // Carry the degenerate flag with the point
    dg_r <= {dg_r[0], degen};
    // Stage 2: sums
    for (int r = 0; r < 3; r++)
      acc_r[r] <= AW'(p_r[r][0]) + AW'(p_r[r][1]) + AW'(p_r[r][2]) + AW'(t_r[r]);
    // Stage 3: round, saturate
    o_r.result_x <= res[0];
    o_r.result_y <= res[1];
    o_r.result_z <= res[2];
    o_r.saturated <= ov[0] | ov[1] | ov[2];
    o_r.degenerate_rotation <= dg_r[1];
  end

  assign out_vld = v_r[2];
  assign out_item = o_r;

endmodule

// File: hdl/trs_vertex_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trs_vertex_transform: translate-rotate-scale point transform
// Points pass the product, sum and round/saturate registers to out_valid,
// one point per cycle while busy is low. A config write holds busy high, cfg_ready
// low, for nine 50-step divisions in one shared divider (a zero quaternion skips them).
// Synchronous reset loads identity rotation, unit scale, zero translation.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module trs_vertex_transform (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tvt_pkg::in_item_t           in_item,
  output logic                        out_valid,
  output tvt_pkg::out_item_t          out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tvt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [31:0]                 cfg_data
);

  logic [31:0] reg_r [tvt_pkg::NUM_REGS];
  logic kick_r;
  tvt_pkg::build_stat_t bst;
  logic signed [tvt_pkg::CW-1:0] coef [9];
  tvt_pkg::row_t rows [3];
  logic acc_in;

  // Accept a register write only while the builder is idle
  assign cfg_ready = !bst.busy;
  assign acc_in = start && !busy;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r[tvt_pkg::REG_TX] <= '0;
      reg_r[tvt_pkg::REG_TY] <= '0;
      reg_r[tvt_pkg::REG_TZ] <= '0;
      reg_r[tvt_pkg::REG_QXY] <= '0;
      reg_r[tvt_pkg::REG_QZW] <= tvt_pkg::QZW_RESET;
      reg_r[tvt_pkg::REG_SX] <= tvt_pkg::ONE_Q16;
      reg_r[tvt_pkg::REG_SY] <= tvt_pkg::ONE_Q16;
      reg_r[tvt_pkg::REG_SZ] <= tvt_pkg::ONE_Q16;
      kick_r <= 1'b0;
    end else begin
      kick_r <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) reg_r[cfg_index] <= cfg_data;
    end
  end

  tvt_matrix_build u_build (
    .clk, .rst_n, .kick(kick_r),
    .qxy(reg_r[tvt_pkg::REG_QXY]), .qzw(reg_r[tvt_pkg::REG_QZW]),
    .sx(reg_r[tvt_pkg::REG_SX]), .sy(reg_r[tvt_pkg::REG_SY]),
    .sz(reg_r[tvt_pkg::REG_SZ]), .coef_o(coef), .stat(bst)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rows[r].m0 = coef[3*r];
      rows[r].m1 = coef[3*r+1];
      rows[r].m2 = coef[3*r+2];
      rows[r].t = reg_r[r];
    end
  end

  assign busy = bst.busy || kick_r || cfg_valid;

  tvt_datapath u_dp (
    .clk, .rst_n, .in_vld(acc_in), .in_item, .rows, .degen(bst.degenerate),
    .out_vld(out_valid), .out_item
  );

  // Checks
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_in, 3)) else $error("result without transaction");
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |-> ##3 out_valid) else $error("transaction lost");
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> busy) else $error("rebuild not flagged");

endmodule
